>>> design/pmu_pkg.sv
// shared types, constants and arithmetic helpers of the particle motion update
`timescale 1ns / 1ps
`default_nettype none
package pmu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int TS_W      = 16;
  localparam int TS_FRAC   = 16;
  localparam int FRAME_W   = 13;
  localparam int LIFE_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int H_W       = 2 * TS_W - TS_FRAC - 1;

  localparam logic [TS_W-1:0]    TS_RESET = TS_W'(2185);
  localparam logic [FRAME_W-1:0] FW_RESET = FRAME_W'(640);
  localparam logic [FRAME_W-1:0] FH_RESET = FRAME_W'(480);

  // squared-length threshold for normalizing, 1.0 in Q.2F
  localparam logic [63:0] UNIT_SQ = 64'd1 << (2 * FRAC_BITS);

  // about 0.001 in Q.F
  localparam logic [DATA_W-1:0] DEAD_ZONE =
    DATA_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

  localparam int ROOT_W         = 32;
  localparam int SQRT_STEPS     = 32;
  localparam int SQRT_PER_STAGE = 2;
  localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;

  localparam int Q_W           = FRAC_BITS + 1;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = (Q_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP    = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] dir_x;
    logic signed [DATA_W-1:0] dir_y;
    logic [LIFE_W-1:0]        life;
    logic                     norm;
  } part_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_pos_x;
    logic signed [DATA_W-1:0] new_pos_y;
    logic signed [DATA_W-1:0] new_vel_x;
    logic signed [DATA_W-1:0] new_vel_y;
    logic [LIFE_W-1:0]        new_life;
    logic                     keep;
  } res_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sq_state_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [Q_W-1:0]    q;
  } div_state_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (x > hi) return DATA_W'(hi);
    if (x < lo) return DATA_W'(lo);
    return x[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] x);
    return x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
  endfunction

  function automatic logic signed [DATA_W-1:0] dead_zone(
    input logic signed [DATA_W-1:0] v);
    return (mag32(v) < DEAD_ZONE) ? '0 : v;
  endfunction

  // one digit of the square root recurrence, step idx from the top
  function automatic sq_state_t isqrt_step(input sq_state_t s, input int idx);
    logic [63:0] bitv;
    sq_state_t   o;
    bitv = 64'd1 << (62 - 2 * idx);
    if (s.v >= s.r + bitv) begin
      o.v = s.v - (s.r + bitv);
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.v = s.v;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // one restoring division step
  function automatic div_state_t div_step(input div_state_t s,
                                          input logic [ROOT_W-1:0] d,
                                          input logic inbit);
    logic [ROOT_W:0] r2;
    div_state_t      o;
    r2 = {s.rem, inbit};
    if (r2 >= {1'b0, d}) begin
      o.rem = ROOT_W'(r2 - {1'b0, d});
      o.q   = {s.q[Q_W-2:0], 1'b1};
    end else begin
      o.rem = r2[ROOT_W-1:0];
      o.q   = {s.q[Q_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> design/pmu_front.sv
// front stages: register the item, square the direction, sum the length
`timescale 1ns / 1ps
`default_nettype none
module pmu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  pmu_pkg::part_t in_part,
  output logic          out_valid,
  output pmu_pkg::part_t out_part,
  output logic [63:0]   out_rad
);
  import pmu_pkg::*;

  logic               v1_r;
  part_t              p1_r;
  logic signed [63:0] sqx_r, sqy_r, sqx_nxt, sqy_nxt;
  logic               v2_r;
  part_t              p2_r, p2_nxt;
  logic [63:0]        rad_r, rad_nxt;

  assign sqx_nxt = 64'(in_part.dir_x) * 64'(in_part.dir_x);
  assign sqy_nxt = 64'(in_part.dir_y) * 64'(in_part.dir_y);

  always_comb begin
    rad_nxt     = $unsigned(sqx_r) + $unsigned(sqy_r);
    p2_nxt      = p1_r;
    p2_nxt.norm = rad_nxt > UNIT_SQ;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r  <= in_part;
      sqx_r <= sqx_nxt;
      sqy_r <= sqy_nxt;
      p2_r  <= p2_nxt;
      rad_r <= rad_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_part  = p2_r;
  assign out_rad   = rad_r;
endmodule
`default_nettype wire

>>> design/pmu_isqrt.sv
// pipelined integer square root of the squared direction length
`timescale 1ns / 1ps
`default_nettype none
module pmu_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_valid,
  input  pmu_pkg::part_t            in_part,
  input  logic [63:0]               in_rad,
  output logic                      out_valid,
  output pmu_pkg::part_t            out_part,
  output logic [pmu_pkg::ROOT_W-1:0] out_root
);
  import pmu_pkg::*;

  logic      val_r  [SQRT_STAGES];
  part_t     part_r [SQRT_STAGES];
  sq_state_t st_r   [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic      src_val;
    part_t     src_part;
    sq_state_t src_st;
    sq_state_t st_nxt;

    if (k == 0) begin : g_first
      assign src_val  = in_valid;
      assign src_part = in_part;
      assign src_st   = '{v: in_rad, r: 64'd0};
    end else begin : g_next
      assign src_val  = val_r[k-1];
      assign src_part = part_r[k-1];
      assign src_st   = st_r[k-1];
    end

    always_comb begin
      st_nxt = src_st;
      for (int i = 0; i < SQRT_PER_STAGE; i++) begin
        st_nxt = isqrt_step(st_nxt, k * SQRT_PER_STAGE + i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[k] <= 1'b0;
      end else if (adv) begin
        val_r[k] <= src_val;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        part_r[k] <= src_part;
        st_r[k]   <= st_nxt;
      end
    end
  end

  assign out_valid = val_r[SQRT_STAGES-1];
  assign out_part  = part_r[SQRT_STAGES-1];
  assign out_root  = st_r[SQRT_STAGES-1].r[ROOT_W-1:0];
endmodule
`default_nettype wire

>>> design/pmu_div.sv
// pipelined restoring divider scaling both direction components to unit length
`timescale 1ns / 1ps
`default_nettype none
module pmu_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_valid,
  input  pmu_pkg::part_t            in_part,
  input  logic [pmu_pkg::ROOT_W-1:0] in_root,
  output logic                      out_valid,
  output pmu_pkg::part_t            out_part,
  output logic [pmu_pkg::Q_W-1:0]   out_qx,
  output logic [pmu_pkg::Q_W-1:0]   out_qy
);
  import pmu_pkg::*;

  logic              val_r  [DIV_STAGES];
  part_t             part_r [DIV_STAGES];
  logic [ROOT_W-1:0] s_r    [DIV_STAGES];
  div_state_t        dx_r   [DIV_STAGES];
  div_state_t        dy_r   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic              src_val;
    part_t             src_part;
    logic [ROOT_W-1:0] src_s;
    div_state_t        src_x, src_y, x_nxt, y_nxt;
    logic              bit_x, bit_y;

    if (k == 0) begin : g_first
      logic [DATA_W-1:0] mx, my;
      assign mx       = mag32(in_part.dir_x);
      assign my       = mag32(in_part.dir_y);
      assign src_val  = in_valid;
      assign src_part = in_part;
      assign src_s    = in_root;
      // numerator is |d| << F; the quotient fits F+1 bits, so start at |d| >> 1
      assign src_x    = '{rem: ROOT_W'(mx >> 1), q: '0};
      assign src_y    = '{rem: ROOT_W'(my >> 1), q: '0};
      assign bit_x    = mx[0];
      assign bit_y    = my[0];
    end else begin : g_next
      assign src_val  = val_r[k-1];
      assign src_part = part_r[k-1];
      assign src_s    = s_r[k-1];
      assign src_x    = dx_r[k-1];
      assign src_y    = dy_r[k-1];
      assign bit_x    = 1'b0;
      assign bit_y    = 1'b0;
    end

    always_comb begin
      x_nxt = src_x;
      y_nxt = src_y;
      for (int i = 0; i < DIV_PER_STAGE; i++) begin
        if (k * DIV_PER_STAGE + i < Q_W) begin
          x_nxt = div_step(x_nxt, src_s, (k * DIV_PER_STAGE + i == 0) ? bit_x : 1'b0);
          y_nxt = div_step(y_nxt, src_s, (k * DIV_PER_STAGE + i == 0) ? bit_y : 1'b0);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[k] <= 1'b0;
      end else if (adv) begin
        val_r[k] <= src_val;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        part_r[k] <= src_part;
        s_r[k]    <= src_s;
        dx_r[k]   <= x_nxt;
        dy_r[k]   <= y_nxt;
      end
    end
  end

  assign out_valid = val_r[DIV_STAGES-1];
  assign out_part  = part_r[DIV_STAGES-1];
  assign out_qx    = dx_r[DIV_STAGES-1].q;
  assign out_qy    = dy_r[DIV_STAGES-1].q;
endmodule
`default_nettype wire

>>> design/pmu_kin.sv
// kinematics stages: acceleration, step products, integration, frame check
`timescale 1ns / 1ps
`default_nettype none
module pmu_kin (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  pmu_pkg::part_t              in_part,
  input  logic [pmu_pkg::Q_W-1:0]     in_qx,
  input  logic [pmu_pkg::Q_W-1:0]     in_qy,
  input  logic [pmu_pkg::TS_W-1:0]    time_step,
  input  logic [pmu_pkg::FRAME_W-1:0] frame_width,
  input  logic [pmu_pkg::FRAME_W-1:0] frame_height,
  output logic                        out_valid,
  output pmu_pkg::res_t               out_res
);
  import pmu_pkg::*;

  localparam int P_W  = DATA_W + H_W + 1;
  localparam int T_W  = DATA_W + TS_W + 1;
  localparam int S_W  = T_W + 1;
  localparam int M_W  = S_W + 6;
  localparam int DP_W = M_W - TS_FRAC;
  localparam int DV_W = T_W - TS_FRAC;

  typedef struct packed {
    logic signed [DATA_W-1:0] ax;
    logic signed [DATA_W-1:0] ay;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic [LIFE_W-1:0]        life;
  } acc_t;

  typedef struct packed {
    logic signed [P_W-1:0]    axh;
    logic signed [P_W-1:0]    ayh;
    logic signed [T_W-1:0]    vxt;
    logic signed [T_W-1:0]    vyt;
    logic signed [T_W-1:0]    axt;
    logic signed [T_W-1:0]    ayt;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic [LIFE_W-1:0]        life;
  } prod_t;

  typedef struct packed {
    logic signed [DP_W-1:0]   dpx;
    logic signed [DP_W-1:0]   dpy;
    logic signed [DV_W-1:0]   dvx;
    logic signed [DV_W-1:0]   dvy;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic [LIFE_W-1:0]        life;
  } delta_t;

  logic           v1_r, v2_r, v3_r, v4_r;
  acc_t           a_r, a_nxt;
  prod_t          m_r, m_nxt;
  delta_t         d_r, d_nxt;
  res_t           o_r, o_nxt;
  logic [H_W-1:0] h_r, h_nxt;

  // dt*dt/2 in Q0.16
  assign h_nxt = H_W'((32'(time_step) * 32'(time_step)) >> (TS_FRAC + 1));

  function automatic logic signed [DATA_W-1:0] accel(
    input logic signed [DATA_W-1:0] d, input logic norm, input logic [Q_W-1:0] q,
    input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] qs;
    logic signed [DATA_W-1:0] dd;
    logic signed [63:0]       d64;
    logic signed [63:0]       v64;
    qs  = $signed(DATA_W'(q));
    dd  = norm ? (d[DATA_W-1] ? -qs : qs) : d;
    d64 = {{(64-DATA_W){dd[DATA_W-1]}}, dd};
    v64 = {{(64-DATA_W){v[DATA_W-1]}}, v};
    return sat32(d64 * 64'sd150 - ((v64 * 64'sd3) >>> 1));
  endfunction

  always_comb begin
    a_nxt.ax   = accel(in_part.dir_x, in_part.norm, in_qx, in_part.vel_x);
    a_nxt.ay   = accel(in_part.dir_y, in_part.norm, in_qy, in_part.vel_y);
    a_nxt.px   = in_part.pos_x;
    a_nxt.py   = in_part.pos_y;
    a_nxt.vx   = in_part.vel_x;
    a_nxt.vy   = in_part.vel_y;
    a_nxt.life = in_part.life;
  end

  always_comb begin
    m_nxt.axh  = P_W'(a_r.ax) * P_W'($signed({1'b0, h_r}));
    m_nxt.ayh  = P_W'(a_r.ay) * P_W'($signed({1'b0, h_r}));
    m_nxt.vxt  = T_W'(a_r.vx) * T_W'($signed({1'b0, time_step}));
    m_nxt.vyt  = T_W'(a_r.vy) * T_W'($signed({1'b0, time_step}));
    m_nxt.axt  = T_W'(a_r.ax) * T_W'($signed({1'b0, time_step}));
    m_nxt.ayt  = T_W'(a_r.ay) * T_W'($signed({1'b0, time_step}));
    m_nxt.px   = a_r.px;
    m_nxt.py   = a_r.py;
    m_nxt.vx   = a_r.vx;
    m_nxt.vy   = a_r.vy;
    m_nxt.life = a_r.life;
  end

  always_comb begin
    logic signed [S_W-1:0] sx, sy;
    logic signed [M_W-1:0] mx, my;
    sx = S_W'(m_r.axh) + S_W'(m_r.vxt);
    sy = S_W'(m_r.ayh) + S_W'(m_r.vyt);
    mx = M_W'(sx) * M_W'(60);
    my = M_W'(sy) * M_W'(60);
    // floor shift is the upper slice
    d_nxt.dpx  = mx[M_W-1:TS_FRAC];
    d_nxt.dpy  = my[M_W-1:TS_FRAC];
    d_nxt.dvx  = m_r.axt[T_W-1:TS_FRAC];
    d_nxt.dvy  = m_r.ayt[T_W-1:TS_FRAC];
    d_nxt.px   = m_r.px;
    d_nxt.py   = m_r.py;
    d_nxt.vx   = m_r.vx;
    d_nxt.vy   = m_r.vy;
    d_nxt.life = m_r.life;
  end

  always_comb begin
    logic signed [DATA_W-1:0] nx, ny;
    logic [FRAME_W+FRAC_BITS-1:0] wx, hy;
    logic in_frame;
    nx = sat32(64'(d_r.px) + 64'(d_r.dpx));
    ny = sat32(64'(d_r.py) + 64'(d_r.dpy));
    wx = {frame_width, {FRAC_BITS{1'b0}}};
    hy = {frame_height, {FRAC_BITS{1'b0}}};
    in_frame = !nx[DATA_W-1] && !ny[DATA_W-1] &&
               (64'(nx[DATA_W-2:0]) <= 64'(wx)) && (64'(ny[DATA_W-2:0]) <= 64'(hy));
    o_nxt.new_pos_x = nx;
    o_nxt.new_pos_y = ny;
    o_nxt.new_vel_x = dead_zone(sat32(64'(d_r.vx) + 64'(d_r.dvx)));
    o_nxt.new_vel_y = dead_zone(sat32(64'(d_r.vy) + 64'(d_r.dvy)));
    o_nxt.keep      = (d_r.life != '0) && in_frame;
    o_nxt.new_life  = o_nxt.keep ? d_r.life - LIFE_W'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    if (adv) begin
      a_r <= a_nxt;
      m_r <= m_nxt;
      d_r <= d_nxt;
      o_r <= o_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_res   = o_r;
endmodule
`default_nettype wire

>>> design/particle_motion_update.sv
// top level of the particle motion update pipeline
`timescale 1ns / 1ps
`default_nettype none
// One particle per item, one item per clock: the pipeline takes a new item every
// cycle while out_stall is low. An item passes 31 register stages (2 front stages,
// 16 square-root stages, 9 divider stages and 4 kinematics stages, the last of which
// is the output register, from which the result is offered). All stages move
// together; a stalled result freezes the whole pipeline and in_stall follows it.
// Configuration writes are always taken (cfg_ready is tied high) and should only
// be issued while no item is in flight.
module particle_motion_update (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_pos_x,
  input  logic signed [31:0]            in_pos_y,
  input  logic signed [31:0]            in_vel_x,
  input  logic signed [31:0]            in_vel_y,
  input  logic signed [31:0]            in_dir_x,
  input  logic signed [31:0]            in_dir_y,
  input  logic [15:0]                   in_life_left,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_new_pos_x,
  output logic signed [31:0]            out_new_pos_y,
  output logic signed [31:0]            out_new_vel_x,
  output logic signed [31:0]            out_new_vel_y,
  output logic [15:0]                   out_new_life,
  output logic                          out_keep,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pmu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmu_pkg::CFG_W-1:0]     cfg_data
);
  import pmu_pkg::*;

  logic               adv;
  logic [TS_W-1:0]    ts_r;
  logic [FRAME_W-1:0] fw_r, fh_r;

  part_t             in_part;
  logic              f_valid, s_valid, d_valid, k_valid;
  part_t             f_part, s_part, d_part;
  logic [63:0]       f_rad;
  logic [ROOT_W-1:0] s_root;
  logic [Q_W-1:0]    d_qx, d_qy;
  res_t              k_res;

  assign adv       = !(k_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= TS_RESET;
      fw_r <= FW_RESET;
      fh_r <= FH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIME_STEP:    ts_r <= cfg_data[TS_W-1:0];
        REG_FRAME_WIDTH:  fw_r <= cfg_data[FRAME_W-1:0];
        REG_FRAME_HEIGHT: fh_r <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_part = '{pos_x: in_pos_x, pos_y: in_pos_y, vel_x: in_vel_x, vel_y: in_vel_y,
                     dir_x: in_dir_x, dir_y: in_dir_y, life: in_life_left, norm: 1'b0};

  pmu_front u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid), .in_part(in_part),
    .out_valid(f_valid), .out_part(f_part), .out_rad(f_rad)
  );

  pmu_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(f_valid), .in_part(f_part),
    .in_rad(f_rad), .out_valid(s_valid), .out_part(s_part), .out_root(s_root)
  );

  pmu_div u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(s_valid), .in_part(s_part),
    .in_root(s_root), .out_valid(d_valid), .out_part(d_part), .out_qx(d_qx), .out_qy(d_qy)
  );

  pmu_kin u_kin (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(d_valid), .in_part(d_part),
    .in_qx(d_qx), .in_qy(d_qy), .time_step(ts_r), .frame_width(fw_r),
    .frame_height(fh_r), .out_valid(k_valid), .out_res(k_res)
  );

  assign out_valid     = k_valid;
  assign out_new_pos_x = k_res.new_pos_x;
  assign out_new_pos_y = k_res.new_pos_y;
  assign out_new_vel_x = k_res.new_vel_x;
  assign out_new_vel_y = k_res.new_vel_y;
  assign out_new_life  = k_res.new_life;
  assign out_keep      = k_res.keep;
endmodule
`default_nettype wire

>>> design/pmu_checker.sv
// port-level checks of the particle motion update and their binding
`timescale 1ns / 1ps
`default_nettype none
module pmu_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_stall,
  input wire               out_valid,
  input wire               out_stall,
  input wire signed [31:0] out_new_pos_x,
  input wire signed [31:0] out_new_pos_y,
  input wire [15:0]        out_new_life,
  input wire               out_keep
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // a dropped item reports zero life
  a_drop_life: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_keep |-> out_new_life == 16'd0)
    else $error("dropped item with nonzero life");

  // a kept item lies inside the frame, so both coordinates are non-negative
  a_keep_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_keep |-> !out_new_pos_x[31] && !out_new_pos_y[31])
    else $error("kept item outside the frame");

endmodule

bind particle_motion_update pmu_checker u_pmu_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_new_pos_x(out_new_pos_x), .out_new_pos_y(out_new_pos_y),
  .out_new_life(out_new_life), .out_keep(out_keep)
);
`default_nettype wire
